// ===== rtl/afct_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the octant plane table for the box frustum cull test.
// Used by afct_plane_test and aabb_frustum_cull_test; depends on nothing.
package afct_pkg;

	localparam int COORD_BITS_DEF  = 16;
	localparam int NORMAL_BITS_DEF = 12;
	localparam int CENTER_BITS     = 16;
	localparam int AXIS_BITS       = 10;
	localparam int CFG_WIDTH       = 64;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CENTER_WIDTH    = 3 * CENTER_BITS;
	localparam int AXES_WIDTH      = 6 * AXIS_BITS;

	typedef logic [2:0] plane_idx_t;

	localparam plane_idx_t PLANE_NEAR   = 3'd0;
	localparam plane_idx_t PLANE_FAR    = 3'd1;
	localparam plane_idx_t PLANE_TOP    = 3'd2;
	localparam plane_idx_t PLANE_BOTTOM = 3'd3;
	localparam plane_idx_t PLANE_LEFT   = 3'd4;
	localparam plane_idx_t PLANE_RIGHT  = 3'd5;
	localparam plane_idx_t NUM_PLANES   = 3'd6;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PLANE_NEAR     = 3'd0;
	localparam cfg_idx_t REG_PLANE_FAR      = 3'd1;
	localparam cfg_idx_t REG_PLANE_TOP      = 3'd2;
	localparam cfg_idx_t REG_PLANE_BOTTOM   = 3'd3;
	localparam cfg_idx_t REG_PLANE_LEFT     = 3'd4;
	localparam cfg_idx_t REG_PLANE_RIGHT    = 3'd5;
	localparam cfg_idx_t REG_FRUSTUM_CENTER = 3'd6;
	localparam cfg_idx_t REG_VIEW_AXES      = 3'd7;

	// Octant index is {right > 0, up > 0, backward > 0}.
	localparam plane_idx_t OCT_TABLE [8][3] = '{
		'{PLANE_LEFT,  PLANE_BOTTOM, PLANE_FAR},
		'{PLANE_LEFT,  PLANE_BOTTOM, PLANE_NEAR},
		'{PLANE_LEFT,  PLANE_TOP,    PLANE_FAR},
		'{PLANE_LEFT,  PLANE_TOP,    PLANE_NEAR},
		'{PLANE_RIGHT, PLANE_BOTTOM, PLANE_FAR},
		'{PLANE_RIGHT, PLANE_BOTTOM, PLANE_NEAR},
		'{PLANE_RIGHT, PLANE_TOP,    PLANE_FAR},
		'{PLANE_RIGHT, PLANE_TOP,    PLANE_NEAR}
	};

	// Load strobes for the multiply and compare stages.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} afct_adv_t;

endpackage

// ===== rtl/afct_plane_test.sv =====
`timescale 1ns / 1ps
// One plane against one box: nearest-corner select and multiply, then sum and compare.
// Two register stages (_s2, _s3); uses afct_pkg.
module afct_plane_test #(
	parameter int COORD_BITS  = afct_pkg::COORD_BITS_DEF,
	parameter int NORMAL_BITS = afct_pkg::NORMAL_BITS_DEF
) (
	input  logic                         clk,
	input  afct_pkg::afct_adv_t          adv,
	input  logic signed [COORD_BITS-1:0] lo [3],
	input  logic signed [COORD_BITS-1:0] hi [3],
	input  logic [afct_pkg::CFG_WIDTH-1:0] plane,
	output logic                         outside_s3
);
	import afct_pkg::*;

	localparam int PW = NORMAL_BITS + COORD_BITS;
	localparam int SW = PW + 2;
	localparam int OW = CFG_WIDTH - 3 * NORMAL_BITS;
	localparam int CW = ((SW > OW) ? SW : OW) + 1;

	logic signed [NORMAL_BITS-1:0] n_w [3];
	logic signed [COORD_BITS-1:0]  c_w [3];
	logic signed [PW-1:0]          prod_s2 [3];
	logic signed [SW-1:0]          dot_w;
	logic signed [OW-1:0]          offs_w;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_w[k] = $signed(plane[k*NORMAL_BITS +: NORMAL_BITS]);
			// nearest corner: min where the normal points positive
			c_w[k] = (!n_w[k][NORMAL_BITS-1] && (n_w[k] != '0)) ? lo[k] : hi[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			for (int k = 0; k < 3; k++)
				prod_s2[k] <= PW'(n_w[k]) * PW'(c_w[k]);
		end
	end

	assign dot_w  = SW'(prod_s2[0]) + SW'(prod_s2[1]) + SW'(prod_s2[2]);
	assign offs_w = $signed(plane[CFG_WIDTH-1:3*NORMAL_BITS]);

	always_ff @(posedge clk) begin
		if (adv.ld_s3)
			outside_s3 <= (CW'(dot_w) > CW'(offs_w));
	end

endmodule

// ===== rtl/aabb_frustum_cull_test.sv =====
`timescale 1ns / 1ps
// Top level of the box frustum cull test: config registers, octant path, final select.
// Uses afct_pkg and afct_plane_test.
//
// Usage:
//   Config: write plane_near..plane_right, frustum_center and view_axes through
//   cfg_wr_en / cfg_index / cfg_data while no box is in flight. Reset clears all.
//   Input: one box (min/max corners) plus its cached plane per transaction on
//   in_valid / in_stall. Output: one transaction per box on out_valid /
//   out_stall carrying outside and new_cached_plane, in input order.
//   Path: a box passes through four register stages (input, multiply, sum and
//   compare, plane select) on its way to out_valid.
//   Throughput: one box per cycle while out_stall is low; all six planes
//   and the octant axes are evaluated in parallel multiplier lanes.
//   Stall: out_stall holds the output register; in_stall rises only when every
//   stage holds a valid box, so bubbles are squeezed out while stalled.
//   Reset: arst_n clears all valid bits and config registers asynchronously.
module aabb_frustum_cull_test #(
	parameter int COORD_BITS  = afct_pkg::COORD_BITS_DEF,
	parameter int NORMAL_BITS = afct_pkg::NORMAL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [afct_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [afct_pkg::CFG_WIDTH-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COORD_BITS-1:0]      min_x,
	input  logic signed [COORD_BITS-1:0]      min_y,
	input  logic signed [COORD_BITS-1:0]      min_z,
	input  logic signed [COORD_BITS-1:0]      max_x,
	input  logic signed [COORD_BITS-1:0]      max_y,
	input  logic signed [COORD_BITS-1:0]      max_z,
	input  logic [2:0]                        cached_plane,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              outside,
	output logic [2:0]                        new_cached_plane
);
	import afct_pkg::*;

	localparam int DW  = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS) + 2;
	localparam int RPW = AXIS_BITS + DW;
	localparam int BPW = NORMAL_BITS + DW;

	// config registers
	logic [CFG_WIDTH-1:0]    plane_q [NUM_PLANES];
	logic [CENTER_WIDTH-1:0] center_q;
	logic [AXES_WIDTH-1:0]   axes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++)
				plane_q[i] <= '0;
			center_q <= '0;
			axes_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PLANE_NEAR:     plane_q[PLANE_NEAR]   <= cfg_data;
				REG_PLANE_FAR:      plane_q[PLANE_FAR]    <= cfg_data;
				REG_PLANE_TOP:      plane_q[PLANE_TOP]    <= cfg_data;
				REG_PLANE_BOTTOM:   plane_q[PLANE_BOTTOM] <= cfg_data;
				REG_PLANE_LEFT:     plane_q[PLANE_LEFT]   <= cfg_data;
				REG_PLANE_RIGHT:    plane_q[PLANE_RIGHT]  <= cfg_data;
				REG_FRUSTUM_CENTER: center_q <= cfg_data[CENTER_WIDTH-1:0];
				REG_VIEW_AXES:      axes_q   <= cfg_data[AXES_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control: a stage loads when it is empty or the next one moves
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	afct_adv_t adv;

	assign rdy4 = !valid_s4 || !out_stall;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign in_stall = !rdy1;
	assign adv.ld_s2 = rdy2 && valid_s1;
	assign adv.ld_s3 = rdy3 && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: box, cached plane and doubled center offset
	logic signed [COORD_BITS-1:0] lo_s1 [3];
	logic signed [COORD_BITS-1:0] hi_s1 [3];
	logic signed [DW-1:0]         d_s1 [3];
	logic [2:0]                   cached_s1, cached_s2, cached_s3;
	logic signed [COORD_BITS-1:0] lo_w [3];
	logic signed [COORD_BITS-1:0] hi_w [3];
	logic signed [DW-1:0]         d_w [3];

	assign lo_w[0] = min_x;
	assign lo_w[1] = min_y;
	assign lo_w[2] = min_z;
	assign hi_w[0] = max_x;
	assign hi_w[1] = max_y;
	assign hi_w[2] = max_z;

	always_comb begin
		for (int k = 0; k < 3; k++)
			d_w[k] = DW'(lo_w[k]) + DW'(hi_w[k])
				- (DW'($signed(center_q[k*CENTER_BITS +: CENTER_BITS])) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int k = 0; k < 3; k++) begin
				lo_s1[k] <= lo_w[k];
				hi_s1[k] <= hi_w[k];
				d_s1[k]  <= d_w[k];
			end
			cached_s1 <= cached_plane;
		end
	end

	// stages 2 and 3: six plane lanes
	logic [NUM_PLANES-1:0] plane_out_s3;

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		afct_plane_test #(
			.COORD_BITS  (COORD_BITS),
			.NORMAL_BITS (NORMAL_BITS)
		) u_plane (
			.clk        (clk),
			.adv        (adv),
			.lo         (lo_s1),
			.hi         (hi_s1),
			.plane      (plane_q[p]),
			.outside_s3 (plane_out_s3[p])
		);
	end

	// stage 2: products of the center offset with the right and up axes and the near-plane normal
	logic signed [RPW-1:0] rp_s2 [3];
	logic signed [RPW-1:0] up_s2 [3];
	logic signed [BPW-1:0] bp_s2 [3];

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			for (int k = 0; k < 3; k++) begin
				rp_s2[k] <= RPW'($signed(axes_q[k*AXIS_BITS +: AXIS_BITS])) * RPW'(d_s1[k]);
				up_s2[k] <= RPW'($signed(axes_q[(k+3)*AXIS_BITS +: AXIS_BITS]))
					* RPW'(d_s1[k]);
				bp_s2[k] <= BPW'($signed(plane_q[PLANE_NEAR][k*NORMAL_BITS +: NORMAL_BITS]))
					* BPW'(d_s1[k]);
			end
			cached_s2 <= cached_s1;
		end
	end

	// stage 3: octant from the signs of the sums
	logic signed [RPW+1:0] dr_w, du_w;
	logic signed [BPW+1:0] db_w;
	logic [2:0]            oct_s3;

	assign dr_w = (RPW+2)'(rp_s2[0]) + (RPW+2)'(rp_s2[1]) + (RPW+2)'(rp_s2[2]);
	assign du_w = (RPW+2)'(up_s2[0]) + (RPW+2)'(up_s2[1]) + (RPW+2)'(up_s2[2]);
	assign db_w = (BPW+2)'(bp_s2[0]) + (BPW+2)'(bp_s2[1]) + (BPW+2)'(bp_s2[2]);

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			oct_s3[2] <= !dr_w[RPW+1] && (dr_w != '0);
			oct_s3[1] <= !du_w[RPW+1] && (du_w != '0);
			oct_s3[0] <= !db_w[BPW+1] && (db_w != '0);
			cached_s3 <= cached_s2;
		end
	end

	// stage 4: cached plane first, then the octant's planes in table order
	logic       cached_ok_w;
	logic       hit_w;
	logic [2:0] sel_w;
	plane_idx_t cand_w;

	assign cached_ok_w = cached_s3 < NUM_PLANES;

	always_comb begin
		hit_w  = 1'b0;
		sel_w  = cached_ok_w ? cached_s3 : PLANE_NEAR;
		cand_w = PLANE_NEAR;
		if (cached_ok_w && plane_out_s3[cached_s3]) begin
			hit_w = 1'b1;
		end else begin
			for (int k = 0; k < 3; k++) begin
				cand_w = OCT_TABLE[oct_s3][k];
				if (!hit_w && (cand_w != cached_s3) && plane_out_s3[cand_w]) begin
					hit_w = 1'b1;
					sel_w = cand_w;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			outside          <= hit_w;
			new_cached_plane <= sel_w;
		end
	end

	assign out_valid = valid_s4;

endmodule
